/* hw/rtl/lus_pkg.sv */
// Package for the linear upsampler: job record passed from front to back,
// configuration bundle, register indexes and helper functions.
// No dependencies.
package lus_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    RegFactorCode = 2'd0,
    RegSourceWide = 2'd1,
    RegWidenTo16  = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    Factor1x = 2'd0,
    Factor2x = 2'd1,
    Factor4x = 2'd2
  } factor_code_e;

  typedef struct packed {
    logic [1:0] factor_code;
    logic       source_wide;
    logic       widen_to_16;
  } cfg_t;

  typedef struct packed {
    logic signed [SampleW-1:0] held;
    logic signed [SampleW-1:0] cur;
    logic signed [SampleW-1:0] mid;
    logic                      have_held;
    logic                      fin;
    logic [2:0]                nfac;
  } job_t;

  // outputs per interpolation run
  function automatic logic [2:0] factor_count(logic [1:0] code);
    logic [2:0] n;
    case (code)
      Factor2x: n = 3'd2;
      Factor4x: n = 3'd4;
      default:  n = 3'd1;
    endcase
    return n;
  endfunction

  // floor of the mean of two samples
  function automatic logic signed [SampleW-1:0] halve_sum(logic signed [SampleW-1:0] a,
                                                          logic signed [SampleW-1:0] b);
    logic signed [SampleW:0] s;
    s = {a[SampleW-1], a} + {b[SampleW-1], b};
    return s[SampleW:1];
  endfunction

endpackage

/* hw/rtl/lus_front.sv */
// Front of the linear upsampler: converts input samples, keeps the held
// sample and pushes one job per sample that causes results. Uses lus_pkg.
module lus_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lus_pkg::cfg_t                     cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [lus_pkg::SampleW-1:0] in_sample_i,
  input  logic                              in_final_i,
  input  logic                              q_full_i,
  output logic                              q_push_o,
  output lus_pkg::job_t                     q_job_o
);
  import lus_pkg::*;

  logic signed [SampleW-1:0] held_q, held_d;
  logic                      have_q, have_d;
  logic signed [SampleW-1:0] cur;
  logic                      accept;

  always_comb begin
    if (cfg_i.source_wide) begin
      cur = in_sample_i;
    end else if (cfg_i.widen_to_16) begin
      cur = {~in_sample_i[7], in_sample_i[6:0], 8'h00};
    end else begin
      cur = {8'h00, in_sample_i[7:0]};
    end
  end

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign q_push_o   = accept & (have_q | in_final_i);

  always_comb begin
    q_job_o.held      = held_q;
    q_job_o.cur       = cur;
    q_job_o.mid       = halve_sum(held_q, cur);
    q_job_o.have_held = have_q;
    q_job_o.fin       = in_final_i;
    q_job_o.nfac      = factor_count(cfg_i.factor_code);
  end

  always_comb begin
    held_d = held_q;
    have_d = have_q;
    if (accept) begin
      held_d = cur;
      have_d = ~in_final_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      have_q <= 1'b0;
    end else begin
      held_q <= held_d;
      have_q <= have_d;
    end
  end

endmodule

/* hw/rtl/lus_fifo.sv */
// Short job queue between front and back of the linear upsampler.
// Register based, first word visible at the head. Uses lus_pkg.
module lus_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lus_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output lus_pkg::job_t head_o
);
  import lus_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* hw/rtl/lus_back.sv */
// Back of the linear upsampler: walks the head job one output per cycle, while
// the output stage is empty or being taken, into a registered output stage. Uses lus_pkg.
module lus_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_empty_i,
  input  lus_pkg::job_t                      q_head_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [lus_pkg::SampleW-1:0] out_sample_o,
  output logic                               out_last_o,
  output logic                               out_end_o
);
  import lus_pkg::*;

  logic [2:0]                idx_q, idx_d;
  logic                      ovalid_q, ovalid_d;
  logic signed [SampleW-1:0] osample_q, osample_d;
  logic                      olast_q, olast_d;
  logic                      oend_q, oend_d;

  logic [3:0]                n_total;
  logic                      last_k;
  logic                      load;
  logic                      in_interp;
  logic [1:0]                pos;
  logic signed [SampleW-1:0] value;

  assign n_total = (q_head_i.have_held ? {1'b0, q_head_i.nfac} : 4'd0)
                 + (q_head_i.fin ? {1'b0, q_head_i.nfac} : 4'd0);
  assign last_k  = ({1'b0, idx_q} + 4'd1) == n_total;
  assign load    = ~q_empty_i & (~ovalid_q | out_ready_i);
  assign q_pop_o = load & last_k;

  assign in_interp = q_head_i.have_held & (idx_q < q_head_i.nfac);

  always_comb begin
    case (q_head_i.nfac)
      3'd4:    pos = idx_q[1:0];
      3'd2:    pos = {idx_q[0], 1'b0};
      default: pos = 2'd0;
    endcase
  end

  always_comb begin
    if (!in_interp) begin
      value = q_head_i.cur;
    end else begin
      case (pos)
        2'd1:    value = halve_sum(q_head_i.held, q_head_i.mid);
        2'd2:    value = q_head_i.mid;
        2'd3:    value = halve_sum(q_head_i.mid, q_head_i.cur);
        default: value = q_head_i.held;
      endcase
    end
  end

  always_comb begin
    idx_d     = idx_q;
    ovalid_d  = ovalid_q;
    osample_d = osample_q;
    olast_d   = olast_q;
    oend_d    = oend_q;
    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end
    if (load) begin
      ovalid_d  = 1'b1;
      osample_d = value;
      olast_d   = last_k;
      oend_d    = last_k & q_head_i.fin;
      idx_d     = last_k ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    osample_q <= osample_d;
    olast_q   <= olast_d;
    oend_q    <= oend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o  = ovalid_q;
  assign out_sample_o = osample_q;
  assign out_last_o   = olast_q;
  assign out_end_o    = oend_q;

`ifndef NO_ASSERTIONS
  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_empty_i |-> ({1'b0, idx_q} < n_total))
    else $error("output index beyond run length");
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && oend_q |-> olast_q)
    else $error("end of sound without end of run");
  a_pop_resets_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (idx_q == 3'd0) && ovalid_q && olast_q)
    else $error("job popped without its last output");
  a_idx_zero_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_empty_i |-> (idx_q == 3'd0))
    else $error("run index left over with no job");
`endif

endmodule

/* hw/rtl/linear_upsampler_1x2x4x.sv */
// Linear-interpolation upsampler by 1, 2 or 4, top level.
// Depends on lus_pkg, lus_front, lus_fifo and lus_back.
//
//   channel   dir  handshake               payload
//   s_axis    in   s_axis_tvalid/tready    tdata: sample_in, tlast: is_final
//   m_axis    out  m_axis_tvalid/tready    tdata: out_sample, tlast: last_of_run,
//                                          tuser: end_of_sound
//   cfg       in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One output per cycle from the back stage while m_axis_tready is high; an
// input yields up to 8 outputs (factor for interpolation plus factor copies
// on a final sample).
// Reset clears the configuration, the held sample and the job queue.
// The front keeps accepting while the queue (QueueDepth jobs) has room.
module linear_upsampler_1x2x4x #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample_in
  input  logic        s_axis_tlast,   // is_final
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] out_sample
  output logic        m_axis_tlast,   // last_of_run
  output logic [0:0]  m_axis_tuser    // [0] end_of_sound
);
  import lus_pkg::*;

  cfg_t  cfg_q, cfg_d;
  job_t  push_job, head_job;
  logic  push, pop, full, empty;
  logic  out_end;
  logic signed [SampleW-1:0] out_sample;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegFactorCode: cfg_d.factor_code = cfg_data_i[1:0];
        RegSourceWide: cfg_d.source_wide = cfg_data_i[0];
        RegWidenTo16:  cfg_d.widen_to_16 = cfg_data_i[0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lus_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_sample_i (s_axis_tdata),
    .in_final_i  (s_axis_tlast),
    .q_full_i    (full),
    .q_push_o    (push),
    .q_job_o     (push_job)
  );

  lus_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head_job)
  );

  lus_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (empty),
    .q_head_i     (head_job),
    .q_pop_o      (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sample_o (out_sample),
    .out_last_o   (m_axis_tlast),
    .out_end_o    (out_end)
  );

  assign m_axis_tdata    = out_sample;
  assign m_axis_tuser[0] = out_end;

endmodule

/* verif/linear_upsampler_1x2x4x_tb.sv */
`timescale 1ns / 1ps
// Testbench for linear_upsampler_1x2x4x: directed and random sounds at all factors
// and source formats, each output checked against an in-bench interpolation model.
// Depends on lus_pkg and the linear_upsampler_1x2x4x RTL.
module linear_upsampler_1x2x4x_tb;
  import lus_pkg::*;

  localparam logic [1:0] RegUnused = 2'd3;
  localparam int unsigned RandItems = 300;
  localparam int unsigned SettleCycles = 12;

  typedef struct packed {
    logic [15:0] smp;
    logic        last_of_run;
    logic        end_of_sound;
  } out_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] sample_in
  logic        s_axis_tlast = 1'b0; // is_final
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [15:0] out_sample
  logic        m_axis_tlast;        // last_of_run
  logic [0:0]  m_axis_tuser;        // [0] end_of_sound

  cfg_t               cfg_model = '0;
  logic signed [15:0] held_smp = '0;
  logic               held_valid = 1'b0;
  out_beat_t          pending_out[$];
  bit                 gaps_on = 1'b1;
  int unsigned        n_fail = 0;
  int unsigned        items_in = 0;
  int unsigned        beats_checked = 0;
  int unsigned        sounds_done = 0;

  linear_upsampler_1x2x4x dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .m_axis_tuser
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  function automatic logic signed [15:0] floor_mean(logic signed [15:0] a,
                                                    logic signed [15:0] b);
    logic signed [16:0] s;
    s = 17'(a) + 17'(b);
    return s[16:1];
  endfunction

  function automatic logic signed [15:0] to_out_format(logic [15:0] raw);
    if (cfg_model.source_wide) return raw;
    if (cfg_model.widen_to_16) return {raw[7] ^ 1'b1, raw[6:0], 8'h00};
    return {8'h00, raw[7:0]};
  endfunction

  function automatic void predict_upsample(logic [15:0] raw, logic fin);
    logic signed [15:0] cur;
    logic signed [15:0] mid;
    logic signed [15:0] beats[8];
    int nfac;
    int n;
    cur = to_out_format(raw);
    case (cfg_model.factor_code)
      Factor2x: nfac = 2;
      Factor4x: nfac = 4;
      default:  nfac = 1;
    endcase
    n = 0;
    if (held_valid) begin
      mid = floor_mean(held_smp, cur);
      beats[0] = held_smp;
      if (nfac == 2) beats[1] = mid;
      if (nfac == 4) begin
        beats[1] = floor_mean(held_smp, mid);
        beats[2] = mid;
        beats[3] = floor_mean(mid, cur);
      end
      n = nfac;
    end
    if (fin) begin
      for (int i = 0; i < nfac; i++) beats[n + i] = cur;
      n += nfac;
      sounds_done++;
    end
    held_smp = cur;
    held_valid = !fin;
    for (int i = 0; i < n; i++) begin
      pending_out.push_back('{smp: beats[i], last_of_run: (i == n - 1),
                              end_of_sound: (fin && i == n - 1)});
    end
  endfunction

  function automatic void check_beat(logic [15:0] d, logic l, logic u);
    out_beat_t want;
    if (pending_out.size() == 0) begin
      $error("unexpected output sample %h last %b end %b", d, l, u);
      n_fail++;
      return;
    end
    want = pending_out.pop_front();
    beats_checked++;
    if (d !== want.smp) begin
      $error("out_sample: expected %h, got %h", want.smp, d);
      n_fail++;
    end
    if (l !== want.last_of_run) begin
      $error("last_of_run: expected %b, got %b", want.last_of_run, l);
      n_fail++;
    end
    if (u !== want.end_of_sound) begin
      $error("end_of_sound: expected %b, got %b", want.end_of_sound, u);
      n_fail++;
    end
  endfunction

  // sample the handshake between edges, where it holds until the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !(gaps_on && $urandom_range(0, 99) < 10);
  end

  task automatic send_sample(input logic [15:0] smp, input logic fin);
    if (gaps_on && $urandom_range(0, 99) < 10) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 10);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tlast  <= fin;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    predict_upsample(smp, fin);
    items_in++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    case (idx)
      RegFactorCode: cfg_model.factor_code = val[1:0];
      RegSourceWide: cfg_model.source_wide = val[0];
      RegWidenTo16:  cfg_model.widen_to_16 = val[0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 15))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'h00FF;
      5: return 16'h0080;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_sample(16'h0000, 1'b0);
    send_sample(16'h00FF, 1'b0);
    send_sample(16'h1280, 1'b1);
    send_sample(16'hFF80, 1'b1);
    drain();
  endtask

  task automatic test_register_map();
    write_reg(RegUnused, 8'hFF);
    write_reg(RegFactorCode, {6'h3F, Factor4x});
    write_reg(RegSourceWide, 8'hFE);
    write_reg(RegWidenTo16, 8'hFE);
    send_sample(16'h0010, 1'b0);
    send_sample(16'h0021, 1'b1);
    drain();
    write_reg(RegFactorCode, 8'h03);
    send_sample(16'h0030, 1'b0);
    send_sample(16'h0040, 1'b1);
    drain();
  endtask

  task automatic test_wide_extremes();
    write_reg(RegSourceWide, 8'hFF);
    write_reg(RegFactorCode, {6'h00, Factor4x});
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0001, 1'b1);
    drain();
    write_reg(RegFactorCode, {6'h00, Factor2x});
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    drain();
  endtask

  task automatic test_widen_8bit();
    write_reg(RegSourceWide, 8'h00);
    write_reg(RegWidenTo16, 8'h01);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hAAFF, 1'b0);
    send_sample(16'h0080, 1'b1);
    drain();
  endtask

  task automatic test_config_while_held();
    write_reg(RegWidenTo16, 8'h00);
    write_reg(RegFactorCode, {6'h00, Factor1x});
    send_sample(16'h00FF, 1'b0);
    drain();
    write_reg(RegSourceWide, 8'h01);
    write_reg(RegFactorCode, {6'h00, Factor4x});
    send_sample(16'h8000, 1'b1);
    drain();
    write_reg(RegSourceWide, 8'h00);
    write_reg(RegWidenTo16, 8'h01);
    send_sample(16'h0000, 1'b0);
    drain();
    write_reg(RegWidenTo16, 8'h00);
    send_sample(16'h007F, 1'b1);
    drain();
  endtask

  // Well-formed sounds of random length; some phases end mid-sound so the
  // next setting applies while a sample is held.
  task automatic test_random_sounds(input int unsigned n_items, input bit idle);
    int unsigned target;
    int unsigned phase_end;
    int unsigned len;
    int unsigned phase;
    target = items_in + n_items;
    phase = 0;
    gaps_on = idle;
    while (items_in < target) begin
      drain();
      write_reg(RegFactorCode, {6'($urandom), 2'(phase % 4)});
      write_reg(RegSourceWide, {7'($urandom), 1'($urandom)});
      write_reg(RegWidenTo16, {7'($urandom), 1'($urandom)});
      phase++;
      phase_end = items_in + $urandom_range(15, 40);
      while (items_in < phase_end && items_in < target) begin
        len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 12);
        for (int unsigned k = 1; k <= len; k++) begin
          send_sample(rand_sample(), k == len && $urandom_range(0, 3) != 0);
        end
      end
    end
    drain();
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_register_map();
    test_wide_extremes();
    test_widen_8bit();
    test_config_while_held();
    test_random_sounds(RandItems - 40, 1'b1);
    test_random_sounds(40, 1'b0);
    $display("covered %0d input items in %0d sounds, %0d output samples checked",
             items_in, sounds_done, beats_checked);
    $display("factors 1x/2x/4x and code 3, 8-bit, widened and 16-bit sources");
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
